// ===== rtl/core/dpt_pkg.sv =====
// Package for the delimiter/punctuation tokenizer: shared types, codes and
// the punctuation lookup. No dependencies.

package dpt_pkg;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_PUNCT = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   localparam logic [2:0] REG_DELIMITER_CHAR = 3'd0;
   localparam logic [2:0] REG_PUNCT_ENABLE   = 3'd1;
   localparam logic [2:0] REG_LIMIT_ENABLE   = 3'd2;
   localparam logic [2:0] REG_SPLIT_LIMIT    = 3'd3;
   localparam logic [2:0] REG_STOP_ENABLE    = 3'd4;
   localparam logic [2:0] REG_STOP_CHAR      = 3'd5;

   localparam logic [7:0] DELIMITER_RESET = 8'd32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [7:0]  delimiter_char;
      logic        punct_enable;
      logic        limit_enable;
      logic [15:0] split_limit;
      logic        stop_enable;
      logic [7:0]  stop_char;
   } cfg_type;

   typedef struct packed {
      logic [15:0] token_start;
      logic [15:0] token_end;
      kind_type    token_kind;
      logic        last_in_run;
   } result_type;

   typedef struct packed {
      logic       push;
      logic [1:0] count;
      result_type first;
      result_type second;
   } batch_type;

   function automatic logic is_punct(input logic [7:0] c);
      logic hit;
      case (c) inside
         8'h2F, 8'h2A, 8'h26, 8'h23, 8'h21, 8'h2B, 8'h2D, 8'h3E, 8'h3C,
         8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2C, 8'h2E, 8'h3D,
         8'h3B: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ===== rtl/core/dpt_csr.sv =====
// Configuration registers of the tokenizer.
// Depends on dpt_pkg.

module dpt_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [2:0]       wr_index,
   input  logic [15:0]      wr_data,
   output dpt_pkg::cfg_type cfg
);

   dpt_pkg::cfg_type cfg_ff;
   dpt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            dpt_pkg::REG_DELIMITER_CHAR: cfg_in.delimiter_char = wr_data[7:0];
            dpt_pkg::REG_PUNCT_ENABLE:   cfg_in.punct_enable   = wr_data[0];
            dpt_pkg::REG_LIMIT_ENABLE:   cfg_in.limit_enable   = wr_data[0];
            dpt_pkg::REG_SPLIT_LIMIT:    cfg_in.split_limit    = wr_data;
            dpt_pkg::REG_STOP_ENABLE:    cfg_in.stop_enable    = wr_data[0];
            dpt_pkg::REG_STOP_CHAR:      cfg_in.stop_char      = wr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                <= '0;
         cfg_ff.delimiter_char <= dpt_pkg::DELIMITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/dpt_scan.sv =====
// Scan state and token classification: one accepted byte yields up to two
// results per cycle. Depends on dpt_pkg.

module dpt_scan #(
   parameter logic [15:0] POS_CAP = 16'hFFFF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         char_byte,
   input  logic               is_last,
   input  dpt_pkg::cfg_type   cfg,
   output dpt_pkg::batch_type batch
);

   logic [15:0] position_ff, position_in;
   logic [15:0] token_begin_ff, token_begin_in;
   logic [16:0] token_stop_ff, token_stop_in;
   logic [15:0] split_count_ff, split_count_in;
   logic        stopped_ff, stopped_in;

   logic [15:0] pos_next;
   logic [17:0] word_sum;
   logic [15:0] word_end;
   logic        has_word;
   logic        split_ok;
   dpt_pkg::result_type word_res;
   dpt_pkg::result_type punct_res;

   always_comb begin
      pos_next = (position_ff < POS_CAP) ? position_ff + 16'd1 : POS_CAP;
      word_sum = {2'b00, token_begin_ff} + {1'b0, token_stop_ff} - 18'd1;
      word_end = (word_sum > {2'b00, POS_CAP}) ? POS_CAP : word_sum[15:0];
      has_word = (token_stop_ff != 17'd0);
      split_ok = !cfg.limit_enable || (split_count_ff < cfg.split_limit);

      word_res  = '{token_start: token_begin_ff, token_end: word_end,
                    token_kind: dpt_pkg::KIND_WORD, last_in_run: 1'b1};
      punct_res = '{token_start: position_ff, token_end: position_ff,
                    token_kind: dpt_pkg::KIND_PUNCT, last_in_run: 1'b1};

      batch          = '0;
      batch.push     = accept;
      position_in    = position_ff;
      token_begin_in = token_begin_ff;
      token_stop_in  = token_stop_ff;
      split_count_in = split_count_ff;
      stopped_in     = stopped_ff;

      if (stopped_ff) begin
         batch.count = 2'd0;
      end else if (cfg.stop_enable && char_byte == cfg.stop_char) begin
         batch.count = 2'd1;
         batch.first = '{token_start: token_begin_ff, token_end: position_ff,
                         token_kind: dpt_pkg::KIND_STOP, last_in_run: 1'b1};
         stopped_in  = 1'b1;
      end else if (cfg.punct_enable && dpt_pkg::is_punct(char_byte)) begin
         if (has_word) begin
            batch.count             = 2'd2;
            batch.first             = word_res;
            batch.first.last_in_run = 1'b0;
            batch.second            = punct_res;
         end else begin
            batch.count = 2'd1;
            batch.first = punct_res;
         end
         token_begin_in = pos_next;
         token_stop_in  = 17'd0;
      end else if (char_byte == cfg.delimiter_char && split_ok) begin
         if (split_count_ff != 16'hFFFF) begin
            split_count_in = split_count_ff + 16'd1;
         end
         if (has_word) begin
            batch.count = 2'd1;
            batch.first = word_res;
         end
         token_begin_in = pos_next;
         token_stop_in  = 17'd0;
      end else if (is_last) begin
         batch.count = 2'd1;
         batch.first = '{token_start: token_begin_ff, token_end: position_ff,
                         token_kind: dpt_pkg::KIND_WORD, last_in_run: 1'b1};
      end else if (token_stop_ff != 17'h10000) begin
         token_stop_in = token_stop_ff + 17'd1;
      end

      if (is_last) begin
         position_in    = '0;
         token_begin_in = '0;
         token_stop_in  = '0;
         split_count_in = '0;
         stopped_in     = 1'b0;
      end else begin
         position_in = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         token_begin_ff <= '0;
         token_stop_ff  <= '0;
         split_count_ff <= '0;
         stopped_ff     <= 1'b0;
      end else if (accept) begin
         position_ff    <= position_in;
         token_begin_ff <= token_begin_in;
         token_stop_ff  <= token_stop_in;
         split_count_ff <= split_count_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule

// ===== rtl/core/dpt_queue.sv =====
// Result queue: takes zero, one or two results per cycle and hands out one when out_ready is high.
// Depends on dpt_pkg.

module dpt_queue (
   input  logic                clock,
   input  logic                reset,
   input  dpt_pkg::batch_type  batch,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output dpt_pkg::result_type out_data
);

   dpt_pkg::result_type queue_ff [dpt_pkg::QUEUE_DEPTH];

   logic [dpt_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dpt_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dpt_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [dpt_pkg::QCNT_W-1:0] push_n;
   logic [dpt_pkg::QPTR_W-1:0] wr_ptr_next;
   logic                       pop;

   always_comb begin
      pop         = out_valid && out_ready;
      push_n      = batch.push ? dpt_pkg::QCNT_W'(batch.count) : '0;
      wr_ptr_next = wr_ptr_ff + dpt_pkg::QPTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + push_n[dpt_pkg::QPTR_W-1:0];
      rd_ptr_in   = pop ? rd_ptr_ff + dpt_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in    = count_ff + push_n - dpt_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         queue_ff[wr_ptr_ff] <= batch.first;
      end
      if (push_n == dpt_pkg::QCNT_W'(2)) begin
         queue_ff[wr_ptr_next] <= batch.second;
      end
   end

   assign room      = (count_ff <= dpt_pkg::QCNT_W'(dpt_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = queue_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/delimiter_punct_tokenizer_unit.sv =====
// Top level of the delimiter/punctuation tokenizer.
// Depends on dpt_pkg, dpt_csr, dpt_scan and dpt_queue.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   char_byte, is_last
//   rsp_      out        rsp_valid / rsp_ready   token_start, token_end, token_kind, last_in_run
//   csr_      in         csr_valid / csr_ready   index, wdata
//
// One byte is accepted per cycle while req_ready is high; its results are
// registered in the queue. A byte yields at most two results and the queue
// emits at most one per cycle, so a run of two-result bytes slows input to
// the output rate of the queue. req_ready drops while fewer than two queue
// slots are free, and during reset. Reset is synchronous.

module delimiter_punct_tokenizer_unit #(
   parameter longint unsigned MAX_LEN = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_end,
   output logic [1:0]  rsp_token_kind,
   output logic        rsp_last_in_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [15:0] POS_CAP =
      (MAX_LEN - 64'd1 < 64'd65535) ? 16'(MAX_LEN - 64'd1) : 16'hFFFF;

   dpt_pkg::cfg_type    cfg;
   dpt_pkg::batch_type  batch;
   dpt_pkg::result_type head;
   logic                room;

   assign req_ready = room && !reset;
   assign csr_ready = !reset;

   dpt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   dpt_scan #(
      .POS_CAP (POS_CAP)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_valid && req_ready),
      .char_byte (req_char_byte),
      .is_last   (req_is_last),
      .cfg       (cfg),
      .batch     (batch)
   );

   dpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_token_start = head.token_start;
   assign rsp_token_end   = head.token_end;
   assign rsp_token_kind  = head.token_kind;
   assign rsp_last_in_run = head.last_in_run;

endmodule

// ===== rtl/core/dpt_checker.sv =====
// Port-level checks for the tokenizer top level, with the bind that attaches them.
// Depends on dpt_pkg and delimiter_punct_tokenizer_unit.

module dpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_token_start,
   input logic [15:0] rsp_token_end,
   input logic [1:0]  rsp_token_kind,
   input logic        rsp_last_in_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_start)
         && $stable(rsp_token_end) && $stable(rsp_token_kind)
         && $stable(rsp_last_in_run))
      else $error("Result item changed while stalled.");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_in_run |=> rsp_valid)
      else $error("Second item of a pair is missing.");

   a_punct_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == dpt_pkg::KIND_PUNCT
         |-> rsp_token_start == rsp_token_end && rsp_last_in_run)
      else $error("Punctuation item is not one byte or not last.");

   a_stop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == dpt_pkg::KIND_STOP |-> rsp_last_in_run)
      else $error("Stop item is not the only item of its byte.");

endmodule

bind delimiter_punct_tokenizer_unit dpt_checker u_dpt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_token_start (rsp_token_start),
   .rsp_token_end   (rsp_token_end),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_last_in_run (rsp_last_in_run)
);
